>>> hdl/uvst_pkg.sv
// Shared types, constants and tables of the UV sphere tessellator.
`timescale 1ns / 1ps

package uvst_pkg;

    localparam int MAX_DIV      = 255;
    localparam int IDX_W        = 24;
    localparam int CORDIC_STEPS = 24;
    localparam int ANG_Q_BITS   = 33;
    localparam int UNIT_Q_BITS  = 17;
    localparam int SQRT_STEPS   = 32;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [63:0]        TAN_THRESH  = 64'd11529215046;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIVA, ST_DIVB, ST_CORA, ST_CORB,
        ST_MUL, ST_TSEL, ST_SQRT, ST_DIVT, ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        KIND_POS = 3'd0, KIND_NRM = 3'd1, KIND_TAN = 3'd2,
        KIND_COL = 3'd3, KIND_TRI = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        CFG_CX = 3'd0, CFG_CY = 3'd1, CFG_CZ = 3'd2, CFG_RAD = 3'd3,
        CFG_LON = 3'd4, CFG_LAT = 3'd5, CFG_COL = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        REC_POS, REC_NRM, REC_TAN, REC_COL, REC_UP, REC_LO
    } t_rec;

    // multiplier schedule: operands issued at each step
    typedef enum logic [3:0] {
        MS_NX, MS_NY, MS_PX, MS_PY, MS_PZ, MS_ZZ, MS_XX, MS_YY,
        MS_RI, MS_RI1, MS_ADV, MS_END
    } t_mstep;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    // atan(2^-k) in units of 2^-32 turn
    function automatic logic [29:0] atan_turn(input logic [4:0] k);
        logic [29:0] v;
        case (k)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/uvst_cordic.sv
// Iterative rotation-mode CORDIC: sine and cosine of an angle in turns.
`timescale 1ns / 1ps

module uvst_cordic (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [31:0]              i_angle,
    output logic signed [33:0]       o_cos,
    output logic signed [33:0]       o_sin,
    output uvst_pkg::t_unit_stat     o_stat
);

    logic signed [33:0] r_x, r_y, r_z;
    logic [4:0]         r_k;
    logic               r_flip, r_busy, r_done;

    logic [31:0]        a_plus, a_rot;
    logic               flip;
    logic signed [33:0] dx, dy, at;

    assign a_plus = i_angle + 32'h4000_0000;
    assign flip   = a_plus[31];
    assign a_rot  = flip ? (i_angle ^ 32'h8000_0000) : i_angle;
    assign dx     = r_y >>> r_k;
    assign dy     = r_x >>> r_k;
    assign at     = $signed({4'b0, uvst_pkg::atan_turn(r_k)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_k == 5'(uvst_pkg::CORDIC_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_flip <= flip;
            r_x    <= uvst_pkg::CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= {{2{a_rot[31]}}, a_rot};
            r_k    <= '0;
        end else if (r_busy) begin
            if (!r_z[33]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
            r_k <= r_k + 5'd1;
        end
    end

    assign o_cos       = r_flip ? -r_x : r_x;
    assign o_sin       = r_flip ? -r_y : r_y;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

>>> hdl/uvst_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module uvst_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [47:0]              i_num,
    input  logic [31:0]              i_den,
    input  logic [5:0]               i_steps,
    output logic [32:0]              o_quo,
    output uvst_pkg::t_unit_stat     o_stat
);

    logic [31:0] r_rem, r_den;
    logic [47:0] r_low;
    logic [32:0] r_q;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;

    logic [32:0] trial;
    logic        ge;

    // quotient must fit in i_steps bits, so the top part is below the divisor
    assign trial = {r_rem, r_low[47]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 6'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= 32'(i_num >> i_steps);
            r_low <= i_num << (6'd48 - i_steps);
            r_den <= i_den;
            r_q   <= '0;
            r_cnt <= i_steps;
        end else if (r_busy) begin
            r_rem <= ge ? 32'(trial - {1'b0, r_den}) : trial[31:0];
            r_q   <= {r_q[31:0], ge};
            r_low <= r_low << 1;
            r_cnt <= r_cnt - 6'd1;
        end
    end

    assign o_quo       = r_q;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

>>> hdl/uv_sphere_tessellator_top.sv
// UV sphere tessellator top level: sequencer, shared multiplier, square root, output.
`timescale 1ns / 1ps

// One in-range grid point runs through these steps from its accepted word to the
// next accepted word. First come two 33-step divides for the angles and two
// 24-step CORDIC runs, then the multiplier schedule on the shared multiplier.
// Then come one select state, a 32-step square root and three 17-step divides
// for the tangent. Last come four to six output words at one per cycle while
// the sink takes them, and the block returns to idle to take the next word.
// The bit-serial divider and the CORDIC unit take most of the run's time. A point
// outside the grid is dropped in idle with no output. The input is ready only
// while the block is idle; the last output word may still be waiting then.
module uv_sphere_tessellator_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wen,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [15:0]  i_s_tdata,   // [7:0] stack_index, [15:8] sector_index
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [95:0]  o_m_tdata,   // [31:0] value_a, [63:32] value_b, [95:64] value_c
    output logic [2:0]   o_m_tuser,   // [2:0] record_kind
    output logic         o_m_tlast    // last_of_run
);

    localparam int IW = uvst_pkg::IDX_W;

    // configuration
    logic signed [31:0] r_cx, r_cy, r_cz;
    logic [30:0]        r_rad;
    logic [7:0]         r_lon, r_lat;
    logic [29:0]        r_col;

    logic [IW-1:0]      r_vbase;

    uvst_pkg::t_state   r_state, n_state;
    logic               r_launched;
    logic [7:0]         r_i, r_j, r_ns, r_nl;
    logic [31:0]        r_ast, r_ase;
    logic signed [33:0] r_ci, r_si, r_cj, r_sj, r_nx, r_ny;
    uvst_pkg::t_mstep   r_k;
    logic signed [67:0] r_prod;
    logic [31:0]        r_px, r_py, r_pz;
    logic [63:0]        r_sqa, r_sqb;
    logic [16:0]        r_ri, r_ri1, r_adv;
    logic               r_alt;
    logic [63:0]        r_sv, r_sr, r_sbit;
    logic [4:0]         r_scnt;
    logic [31:0]        r_len;
    logic [1:0]         r_tk;
    logic [31:0]        r_tq [3];
    uvst_pkg::t_rec     r_rec;

    logic               r_ovalid, r_olast;
    uvst_pkg::t_kind    r_okind;
    logic [31:0]        r_oa, r_ob, r_oc;

    // ---------------------------------------------------------------
    logic [7:0]  in_stack, in_sector, ns_c, nl_c;
    logic        acc, in_range;
    logic [8:0]  row;

    assign in_stack  = i_s_tdata[7:0];
    assign in_sector = i_s_tdata[15:8];
    assign ns_c = (r_lat < 8'd2) ? 8'd2 :
                  ((32'(r_lat) > uvst_pkg::MAX_DIV) ? 8'(uvst_pkg::MAX_DIV) : r_lat);
    assign nl_c = (r_lon < 8'd3) ? 8'd3 :
                  ((32'(r_lon) > uvst_pkg::MAX_DIV) ? 8'(uvst_pkg::MAX_DIV) : r_lon);
    assign o_s_tready = (r_state == uvst_pkg::ST_IDLE);
    assign acc        = i_s_tvalid && o_s_tready;
    assign in_range   = (in_stack <= ns_c) && (in_sector <= nl_c);
    assign row        = {1'b0, r_nl} + 9'd1;

    // ---------------------------------------------------------------
    // shared units
    logic                 div_start, cor_start;
    logic [47:0]          div_num;
    logic [31:0]          div_den;
    logic [5:0]           div_steps;
    logic [32:0]          div_quo;
    uvst_pkg::t_unit_stat div_stat, cor_stat;
    logic signed [33:0]   cor_cos, cor_sin;

    logic signed [34:0]   t_val;
    logic [34:0]          t_mag;
    logic [31:0]          t_res;
    logic [32:0]          q_ext;

    always_comb begin
        unique case (r_tk)
            2'd0:    t_val = r_alt ? 35'sd0 : {r_si[33], r_si};
            2'd1:    t_val = r_alt ? -{r_si[33], r_si} : 35'sd0;
            default: t_val = r_alt ? {r_ny[33], r_ny} : -{r_nx[33], r_nx};
        endcase
    end
    assign t_mag = t_val[34] ? 35'(-t_val) : 35'(t_val);
    assign q_ext = {16'b0, div_quo[16:0]};
    assign t_res = t_val[34] ? 32'(-q_ext) : q_ext[31:0];

    always_comb begin
        div_num   = '0;
        div_den   = '0;
        div_steps = 6'(uvst_pkg::ANG_Q_BITS);
        case (r_state)
            uvst_pkg::ST_DIVA: begin
                div_num = (48'(r_i) << 31) + 48'(r_ns >> 1);
                div_den = 32'(r_ns);
            end
            uvst_pkg::ST_DIVB: begin
                div_num = (48'(r_j) << 32) + 48'(r_nl >> 1);
                div_den = 32'(r_nl);
            end
            uvst_pkg::ST_DIVT: begin
                div_num   = {t_mag[31:0], 16'b0} + 48'(r_len >> 1);
                div_den   = r_len;
                div_steps = 6'(uvst_pkg::UNIT_Q_BITS);
            end
            default: ;
        endcase
    end

    assign div_start = !r_launched &&
        ((r_state == uvst_pkg::ST_DIVA) || (r_state == uvst_pkg::ST_DIVB) ||
         ((r_state == uvst_pkg::ST_DIVT) && (r_len != 32'd0)));
    assign cor_start = !r_launched &&
        ((r_state == uvst_pkg::ST_CORA) || (r_state == uvst_pkg::ST_CORB));

    uvst_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_steps (div_steps),
        .o_quo   (div_quo),
        .o_stat  (div_stat)
    );

    uvst_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle ((r_state == uvst_pkg::ST_CORA) ? r_ast : r_ase),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin),
        .o_stat  (cor_stat)
    );

    // ---------------------------------------------------------------
    // multiplier operands
    logic signed [33:0] m_a, m_b;
    logic signed [67:0] p_rnd;
    logic signed [33:0] p_q30;
    logic signed [34:0] p_sum;
    logic [31:0]        p_sat;

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_k)
            uvst_pkg::MS_NX:  begin m_a = r_ci; m_b = r_cj; end
            uvst_pkg::MS_NY:  begin m_a = r_ci; m_b = r_sj; end
            uvst_pkg::MS_PX:  begin m_a = $signed({3'b0, r_rad}); m_b = r_nx; end
            uvst_pkg::MS_PY:  begin m_a = $signed({3'b0, r_rad}); m_b = r_ny; end
            uvst_pkg::MS_PZ:  begin m_a = $signed({3'b0, r_rad}); m_b = r_si; end
            uvst_pkg::MS_ZZ:  begin m_a = r_si; m_b = r_si; end
            uvst_pkg::MS_XX:  begin m_a = r_nx; m_b = r_nx; end
            uvst_pkg::MS_YY:  begin m_a = r_ny; m_b = r_ny; end
            uvst_pkg::MS_RI:  begin m_a = $signed(34'(r_i)); m_b = $signed(34'(row)); end
            uvst_pkg::MS_RI1: begin
                m_a = $signed(34'(r_i) + 34'd1);
                m_b = $signed(34'(row));
            end
            uvst_pkg::MS_ADV: begin
                m_a = $signed(34'(r_ns) + 34'd1);
                m_b = $signed(34'(row));
            end
            default: ;
        endcase
    end

    assign p_rnd = r_prod + 68'sd536870912;
    assign p_q30 = $signed(p_rnd[63:30]);

    // center plus scaled direction, saturated
    always_comb begin
        case (r_k)
            uvst_pkg::MS_PY: p_sum = {{3{r_cx[31]}}, r_cx} + {p_q30[33], p_q30};
            uvst_pkg::MS_PZ: p_sum = {{3{r_cy[31]}}, r_cy} + {p_q30[33], p_q30};
            default:         p_sum = {{3{r_cz[31]}}, r_cz} + {p_q30[33], p_q30};
        endcase
        if (p_sum > 35'sd2147483647)
            p_sat = 32'h7FFF_FFFF;
        else if (p_sum < -35'sd2147483648)
            p_sat = 32'h8000_0000;
        else
            p_sat = p_sum[31:0];
    end

    // ---------------------------------------------------------------
    // square root step
    logic [63:0] s_try, s_nv, s_nr;
    logic        s_ge;

    assign s_try = r_sr + r_sbit;
    assign s_ge  = r_sv >= s_try;
    assign s_nv  = s_ge ? r_sv - s_try : r_sv;
    assign s_nr  = s_ge ? (r_sr >> 1) + r_sbit : r_sr >> 1;

    // ---------------------------------------------------------------
    // output records
    logic          has_cell, has_up, has_lo, rec_last, emit_load, emit_end;
    logic [IW-1:0] k1, k2, k3, k4;
    logic [34:0]   nrm_x, nrm_y, nrm_z;

    assign has_cell  = (r_i < r_ns) && (r_j < r_nl);
    assign has_up    = has_cell && (r_i != 8'd0);
    assign has_lo    = has_cell && (r_i != r_ns - 8'd1);
    assign rec_last  = ((r_rec == uvst_pkg::REC_COL) && !has_up && !has_lo) ||
                       ((r_rec == uvst_pkg::REC_UP) && !has_lo) ||
                       (r_rec == uvst_pkg::REC_LO);
    assign emit_load = (r_state == uvst_pkg::ST_EMIT) && (!r_ovalid || i_m_tready);
    assign emit_end  = emit_load && rec_last;

    assign k1 = r_vbase + IW'(r_ri) + IW'(r_j);
    assign k2 = r_vbase + IW'(r_ri1) + IW'(r_j);
    assign k3 = k1 + IW'(1);
    assign k4 = k2 + IW'(1);

    assign nrm_x = {r_nx[33], r_nx} + 35'sd8192;
    assign nrm_y = {r_ny[33], r_ny} + 35'sd8192;
    assign nrm_z = {r_si[33], r_si} + 35'sd8192;

    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            uvst_pkg::ST_IDLE: if (acc && in_range) n_state = uvst_pkg::ST_DIVA;
            uvst_pkg::ST_DIVA: if (div_stat.done) n_state = uvst_pkg::ST_DIVB;
            uvst_pkg::ST_DIVB: if (div_stat.done) n_state = uvst_pkg::ST_CORA;
            uvst_pkg::ST_CORA: if (cor_stat.done) n_state = uvst_pkg::ST_CORB;
            uvst_pkg::ST_CORB: if (cor_stat.done) n_state = uvst_pkg::ST_MUL;
            uvst_pkg::ST_MUL:  if (r_k == uvst_pkg::MS_END) n_state = uvst_pkg::ST_TSEL;
            uvst_pkg::ST_TSEL: n_state = uvst_pkg::ST_SQRT;
            uvst_pkg::ST_SQRT: begin
                if (r_scnt == 5'(uvst_pkg::SQRT_STEPS - 1)) n_state = uvst_pkg::ST_DIVT;
            end
            uvst_pkg::ST_DIVT: begin
                if ((r_len == 32'd0 || div_stat.done) && r_tk == 2'd2)
                    n_state = uvst_pkg::ST_EMIT;
            end
            uvst_pkg::ST_EMIT: if (emit_end) n_state = uvst_pkg::ST_IDLE;
            default: n_state = uvst_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= uvst_pkg::ST_IDLE;
            r_launched <= 1'b0;
            r_ovalid   <= 1'b0;
            r_vbase    <= '0;
            r_cx       <= '0;
            r_cy       <= '0;
            r_cz       <= '0;
            r_rad      <= 31'd65536;
            r_lon      <= 8'd16;
            r_lat      <= 8'd8;
            r_col      <= 30'h3FFF_FFFF;
        end else begin
            r_state <= n_state;
            if (div_start || cor_start)
                r_launched <= 1'b1;
            else if (div_stat.done || cor_stat.done)
                r_launched <= 1'b0;

            if (i_cfg_wen) begin
                unique case (i_cfg_idx)
                    uvst_pkg::CFG_CX:  r_cx  <= i_cfg_data;
                    uvst_pkg::CFG_CY:  r_cy  <= i_cfg_data;
                    uvst_pkg::CFG_CZ:  r_cz  <= i_cfg_data;
                    uvst_pkg::CFG_RAD: r_rad <= i_cfg_data[30:0];
                    uvst_pkg::CFG_LON: r_lon <= i_cfg_data[7:0];
                    uvst_pkg::CFG_LAT: r_lat <= i_cfg_data[7:0];
                    uvst_pkg::CFG_COL: r_col <= i_cfg_data[29:0];
                    default: ;
                endcase
            end

            if (emit_load)
                r_ovalid <= 1'b1;
            else if (i_m_tready)
                r_ovalid <= 1'b0;

            // the base moves on after the sphere's final grid point
            if (emit_end && r_i == r_ns && r_j == r_nl)
                r_vbase <= r_vbase + IW'(r_adv);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
        case (r_state)
            uvst_pkg::ST_IDLE: begin
                r_i  <= in_stack;
                r_j  <= in_sector;
                r_ns <= ns_c;
                r_nl <= nl_c;
            end
            uvst_pkg::ST_DIVA: if (div_stat.done) r_ast <= 32'h4000_0000 - div_quo[31:0];
            uvst_pkg::ST_DIVB: if (div_stat.done) r_ase <= div_quo[31:0];
            uvst_pkg::ST_CORA: begin
                if (cor_stat.done) begin
                    r_ci <= cor_cos;
                    r_si <= cor_sin;
                end
            end
            uvst_pkg::ST_CORB: begin
                r_k <= uvst_pkg::MS_NX;
                if (cor_stat.done) begin
                    r_cj <= cor_cos;
                    r_sj <= cor_sin;
                end
            end
            uvst_pkg::ST_MUL: begin
                r_k <= uvst_pkg::t_mstep'(r_k + 4'd1);
                // r_prod holds the product issued one step earlier
                case (r_k)
                    uvst_pkg::MS_NY:  r_nx <= p_q30;
                    uvst_pkg::MS_PX:  r_ny <= p_q30;
                    uvst_pkg::MS_PY:  r_px <= p_sat;
                    uvst_pkg::MS_PZ:  r_py <= p_sat;
                    uvst_pkg::MS_ZZ:  r_pz <= p_sat;
                    uvst_pkg::MS_XX:  r_sqa <= r_prod[63:0];
                    uvst_pkg::MS_YY: begin
                        r_sqb <= r_sqa;
                        r_sqa <= r_sqa + r_prod[63:0];
                    end
                    uvst_pkg::MS_RI:  r_sqb <= r_sqb + r_prod[63:0];
                    uvst_pkg::MS_RI1: r_ri  <= r_prod[16:0];
                    uvst_pkg::MS_ADV: r_ri1 <= r_prod[16:0];
                    uvst_pkg::MS_END: r_adv <= r_prod[16:0];
                    default: ;
                endcase
            end
            uvst_pkg::ST_TSEL: begin
                // near a pole the Y-axis cross product vanishes: use the X axis
                r_alt  <= r_sqa < uvst_pkg::TAN_THRESH;
                r_sv   <= (r_sqa < uvst_pkg::TAN_THRESH) ? r_sqb : r_sqa;
                r_sr   <= '0;
                r_sbit <= 64'h4000_0000_0000_0000;
                r_scnt <= '0;
            end
            uvst_pkg::ST_SQRT: begin
                r_sv   <= s_nv;
                r_sr   <= s_nr;
                r_sbit <= r_sbit >> 2;
                r_scnt <= r_scnt + 5'd1;
                r_len  <= s_nr[31:0];
                r_tk   <= '0;
            end
            uvst_pkg::ST_DIVT: begin
                if (r_len == 32'd0 || div_stat.done) begin
                    r_tq[r_tk] <= (r_len == 32'd0) ? 32'd0 : t_res;
                    r_tk       <= r_tk + 2'd1;
                end
                r_rec <= uvst_pkg::REC_POS;
            end
            uvst_pkg::ST_EMIT: begin
                if (emit_load) begin
                    r_olast <= rec_last;
                    case (r_rec)
                        uvst_pkg::REC_POS: begin
                            r_okind <= uvst_pkg::KIND_POS;
                            r_oa <= r_px; r_ob <= r_py; r_oc <= r_pz;
                            r_rec <= uvst_pkg::REC_NRM;
                        end
                        uvst_pkg::REC_NRM: begin
                            r_okind <= uvst_pkg::KIND_NRM;
                            r_oa <= {{11{nrm_x[34]}}, nrm_x[34:14]};
                            r_ob <= {{11{nrm_y[34]}}, nrm_y[34:14]};
                            r_oc <= {{11{nrm_z[34]}}, nrm_z[34:14]};
                            r_rec <= uvst_pkg::REC_TAN;
                        end
                        uvst_pkg::REC_TAN: begin
                            r_okind <= uvst_pkg::KIND_TAN;
                            r_oa <= r_tq[0]; r_ob <= r_tq[1]; r_oc <= r_tq[2];
                            r_rec <= uvst_pkg::REC_COL;
                        end
                        uvst_pkg::REC_COL: begin
                            r_okind <= uvst_pkg::KIND_COL;
                            r_oa <= {22'b0, r_col[29:20]};
                            r_ob <= {22'b0, r_col[19:10]};
                            r_oc <= {22'b0, r_col[9:0]};
                            r_rec <= has_up ? uvst_pkg::REC_UP : uvst_pkg::REC_LO;
                        end
                        uvst_pkg::REC_UP: begin
                            r_okind <= uvst_pkg::KIND_TRI;
                            r_oa <= 32'(k1); r_ob <= 32'(k2); r_oc <= 32'(k3);
                            r_rec <= uvst_pkg::REC_LO;
                        end
                        default: begin
                            r_okind <= uvst_pkg::KIND_TRI;
                            r_oa <= 32'(k3); r_ob <= 32'(k2); r_oc <= 32'(k4);
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {r_oc, r_ob, r_oa};
    assign o_m_tuser  = r_okind;
    assign o_m_tlast  = r_olast;

`ifndef SYNTHESIS
    a_base_moves_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vbase != $past(r_vbase)) |-> ($past(r_state) == uvst_pkg::ST_EMIT))
        else $error("vertex base changed outside record output");

    a_idle_only_last_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (!o_m_tvalid || o_m_tlast))
        else $error("input ready while a run is still being output");

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(div_stat.busy && cor_stat.busy))
        else $error("divider and CORDIC busy together");
`endif

endmodule

>>> verif/tb.sv
// Testbench for the UV sphere tessellator: stream stimulus, scoreboard with built-in predictor.
`timescale 1ns / 1ps

typedef struct {
    uvst_pkg::t_kind kind;
    logic [31:0]     va;
    logic [31:0]     vb;
    logic [31:0]     vc;
    logic            last;
} t_mesh_rec;

class mesh_scoreboard;
    longint          cx, cy, cz;
    longint unsigned rad, lon, lat, color;
    logic [uvst_pkg::IDX_W-1:0] vbase;
    t_mesh_rec       expq[$];
    int              errors;

    static const longint atan_tab[24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81};

    function new();
        cx = 0; cy = 0; cz = 0;
        rad = 65536; lon = 16; lat = 8; color = 30'h3FFFFFFF;
        vbase = '0;
        errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
        case (idx)
            uvst_pkg::CFG_CX:  cx = longint'(signed'(v));
            uvst_pkg::CFG_CY:  cy = longint'(signed'(v));
            uvst_pkg::CFG_CZ:  cz = longint'(signed'(v));
            uvst_pkg::CFG_RAD: rad = v[30:0];
            uvst_pkg::CFG_LON: lon = v[7:0];
            uvst_pkg::CFG_LAT: lat = v[7:0];
            uvst_pkg::CFG_COL: color = v[29:0];
            default: ;
        endcase
    endfunction

    // CORDIC in Q2.30, angle in 2^-32 turn; fold the left half plane first
    function void sin_cos(input logic [31:0] ang, output longint c, output longint s);
        logic [31:0] t;
        longint x, y, z, dx, dy;
        t = ang + 32'h40000000;
        if (t[31]) ang = ang - 32'h80000000;
        x = 652032874; y = 0;
        z = longint'(signed'(ang));
        for (int k = 0; k < 24; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[k];
            end else begin
                x += dx; y -= dy; z += atan_tab[k];
            end
        end
        c = t[31] ? -x : x;
        s = t[31] ? -y : y;
    endfunction

    function longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b; r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function longint to_unit(longint v, longint unsigned len);
        longint unsigned m, q;
        if (len == 0) return 0;
        m = (v < 0) ? -v : v;
        q = (m * 65536 + len / 2) / len;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    function void add_rec(uvst_pkg::t_kind k, longint a, longint b, longint c);
        t_mesh_rec r;
        r.kind = k; r.va = a[31:0]; r.vb = b[31:0]; r.vc = c[31:0]; r.last = 1'b0;
        expq.insert(expq.size(), r);
    endfunction

    function void note_input(logic [7:0] stk, logic [7:0] sec);
        longint unsigned ns, nl, i, j, row, sq, len, k1, k2, k3, k4, msk, nb;
        logic [31:0] ast, ase;
        longint ci, si, cj, sj, nx, ny, nz, r, tx, ty, tz;
        msk = (64'd1 << uvst_pkg::IDX_W) - 1;
        ns = (lat < 2) ? 2 : (lat > uvst_pkg::MAX_DIV) ? uvst_pkg::MAX_DIV : lat;
        nl = (lon < 3) ? 3 : (lon > uvst_pkg::MAX_DIV) ? uvst_pkg::MAX_DIV : lon;
        i = stk; j = sec;
        if (i > ns || j > nl) return;
        row = nl + 1;
        r = longint'(rad);
        ast = 32'h40000000 - 32'(((i << 31) + ns / 2) / ns);
        ase = 32'(((j << 32) + nl / 2) / nl);
        sin_cos(ast, ci, si);
        sin_cos(ase, cj, sj);
        nx = (ci * cj + 536870912) >>> 30;
        ny = (ci * sj + 536870912) >>> 30;
        nz = si;
        add_rec(uvst_pkg::KIND_POS, clip32(cx + ((r * nx + 536870912) >>> 30)),
                clip32(cy + ((r * ny + 536870912) >>> 30)),
                clip32(cz + ((r * nz + 536870912) >>> 30)));
        add_rec(uvst_pkg::KIND_NRM, (nx + 8192) >>> 14, (ny + 8192) >>> 14,
                (nz + 8192) >>> 14);
        tx = nz; ty = 0; tz = -nx;
        sq = nz * nz + nx * nx;
        // near a pole: fall back to the X-axis cross product
        if (sq < 64'd11529215046) begin
            tx = 0; ty = -nz; tz = ny;
            sq = nz * nz + ny * ny;
        end
        len = int_sqrt(sq);
        add_rec(uvst_pkg::KIND_TAN, to_unit(tx, len), to_unit(ty, len), to_unit(tz, len));
        add_rec(uvst_pkg::KIND_COL, color[29:20], color[19:10], color[9:0]);
        if (i < ns && j < nl) begin
            k1 = (vbase + i * row + j) & msk;
            k2 = (vbase + (i + 1) * row + j) & msk;
            k3 = (k1 + 1) & msk;
            k4 = (k2 + 1) & msk;
            if (i != 0) add_rec(uvst_pkg::KIND_TRI, k1, k2, k3);
            if (i != ns - 1) add_rec(uvst_pkg::KIND_TRI, k3, k2, k4);
        end
        if (i == ns && j == nl) begin
            nb = vbase + (ns + 1) * row;
            vbase = nb[uvst_pkg::IDX_W-1:0];
        end
        expq[$].last = 1'b1;
    endfunction

    function void check(logic [2:0] kind, logic [95:0] data, logic last);
        t_mesh_rec e;
        if (expq.size() == 0) begin
            $display("%0t: unexpected word kind=%0d data=%h last=%b", $time, kind, data, last);
            errors++;
            return;
        end
        e = expq.pop_front();
        if (kind !== e.kind) begin
            $display("%0t: kind exp %0d got %0d", $time, e.kind, kind); errors++;
        end
        if (data[31:0] !== e.va) begin
            $display("%0t: value_a exp %h got %h", $time, e.va, data[31:0]); errors++;
        end
        if (data[63:32] !== e.vb) begin
            $display("%0t: value_b exp %h got %h", $time, e.vb, data[63:32]); errors++;
        end
        if (data[95:64] !== e.vc) begin
            $display("%0t: value_c exp %h got %h", $time, e.vc, data[95:64]); errors++;
        end
        if (last !== e.last) begin
            $display("%0t: tlast exp %b got %b", $time, e.last, last); errors++;
        end
    endfunction
endclass

module tb;
    localparam logic [2:0] CFG_NONE = 3'd7;
    localparam int SETTLE = 250;
    localparam int WDOG_LIMIT = 6000;
    localparam int SWEEP_ITEMS = 60;

    logic        i_clk, i_rst_n;
    logic        i_cfg_wen;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        i_s_tvalid, o_s_tready;
    logic [15:0] i_s_tdata;
    logic        o_m_tvalid, i_m_tready;
    logic [95:0] o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        o_m_tlast;

    mesh_scoreboard sb;
    bit no_idle;
    bit hold_req;
    int quiet_cycles;

    uv_sphere_tessellator_top dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic cfg_write(logic [2:0] idx, logic [31:0] v);
        @(posedge i_clk);
        i_cfg_wen  <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        sb.write_reg(idx, v);
    endtask

    task automatic set_sphere(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [31:0] rad, logic [7:0] lon, logic [7:0] lat,
                              logic [29:0] col);
        cfg_write(uvst_pkg::CFG_CX, x);
        cfg_write(uvst_pkg::CFG_CY, y);
        cfg_write(uvst_pkg::CFG_CZ, z);
        cfg_write(uvst_pkg::CFG_RAD, rad);
        cfg_write(uvst_pkg::CFG_LON, lon);
        cfg_write(uvst_pkg::CFG_LAT, lat);
        cfg_write(uvst_pkg::CFG_COL, col);
        cfg_write(CFG_NONE, $urandom);
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
    endtask

    // valid stays up between back-to-back words; lowered only for a gap
    task automatic send_point(logic [7:0] stk, logic [7:0] sec);
        if (!no_idle && $urandom_range(99) < 29) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 29);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {sec, stk};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_input(stk, sec);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.expq.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // sink: random stalls, plus one long hold-off on request
    initial begin
        int hold_cnt;
        bit hold_done;
        hold_cnt = 0;
        hold_done = 0;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready)
                sb.check(o_m_tuser, o_m_tdata, o_m_tlast);
            if (hold_req && !hold_done) begin
                hold_done = 1;
                hold_cnt = 400;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= no_idle || ($urandom_range(99) >= 29);
            end
        end
    end

    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("%0t: timeout, %0d words outstanding", $time, sb.expq.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int n, ci, cj, ns, nl;
        sb = new();
        no_idle = 0;
        hold_req = 0;
        i_rst_n = 1'b0;
        i_cfg_wen = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: poles, seam, interior, points off the grid
        send_point(0, 0);
        send_point(8, 16);
        send_point(8, 0);
        send_point(0, 16);
        send_point(4, 5);
        send_point(255, 255);
        send_point(9, 0);
        send_point(0, 17);
        drain();

        // extreme center and radius, counts below range clamp to 3 x 2
        set_sphere(32'h7FFFFFFF, 32'h80000000, 32'h00000000, 32'h7FFFFFFF, 0, 0, 30'h0);
        for (int i = 0; i <= 2; i++)
            for (int j = 0; j <= 3; j++)
                send_point(i, j);
        send_point(1, 2);
        drain();

        // finest grid, zero radius, no idling on either side
        no_idle = 1;
        set_sphere($urandom, $urandom, $urandom, 0, 255, 255, $urandom);
        send_point(255, 255);
        send_point(128, 200);
        for (n = 0; n < 22; n++)
            send_point($urandom_range(255), $urandom_range(255));
        drain();
        no_idle = 0;

        set_sphere($urandom, $urandom, $urandom, 32'h7FFFFFFF, 1, 1, 30'h3FFFFFFF);
        send_point(2, 3);
        send_point(0, 0);
        drain();

        // small spheres swept in order, with some stray points mixed in
        n = 0;
        while (n < SWEEP_ITEMS) begin
            nl = $urandom_range(3, 6);
            ns = $urandom_range(2, 4);
            set_sphere($urandom, $urandom, $urandom, $urandom_range(0, 32'h7FFFFFFF),
                       nl, ns, $urandom);
            ci = 0;
            cj = 0;
            for (int k = 0; k < 30 && n < SWEEP_ITEMS; k++) begin
                if (n == 40) hold_req = 1;
                if ($urandom_range(99) < 15) begin
                    send_point($urandom_range(255), $urandom_range(255));
                end else begin
                    send_point(ci, cj);
                    n++;
                    if (cj == nl) begin
                        cj = 0;
                        ci = (ci == ns) ? 0 : ci + 1;
                    end else begin
                        cj++;
                    end
                end
            end
            drain();
        end

        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

>>> files.f
hdl/uvst_pkg.sv
hdl/uvst_cordic.sv
hdl/uvst_div.sv
hdl/uv_sphere_tessellator_top.sv
verif/tb.sv
